// ===== hw/rtl/psc_pkg.sv =====
package psc_pkg;

  // size of the candidate bitmap, one bit per value 0 .. MAX_LIMIT_PLUS_ONE-1
  localparam int MAX_LIMIT_PLUS_ONE = 65536;

  localparam int LIMIT_W = 16;
  localparam int COUNT_W = 13;
  localparam int ADDR_W  = $clog2(MAX_LIMIT_PLUS_ONE);
  // index must hold values up to n + base, below twice the bitmap size
  localparam int IDX_W   = ADDR_W + 1;
  // bases never pass sqrt of the bitmap size plus one
  localparam int BASE_W  = ADDR_W / 2 + 1;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  // pi(65535), the largest count a 16-bit limit can give
  localparam logic [COUNT_W-1:0] PRIME_COUNT_MAX = COUNT_W'(6542);

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_FILL,
    DP_BASE_INIT,
    DP_BASE_RD,
    DP_MARK_INIT,
    DP_MARK,
    DP_BASE_NEXT,
    DP_CNT_INIT,
    DP_CNT_RD,
    DP_PUBLISH
  } dp_op_e;

  typedef struct packed {
    logic n_lt2;
    logic idx_eq_n;
    logic idx_gt_n;
    logic sq_gt_n;
    logic base_marked;
  } psc_status_t;

endpackage

// ===== hw/rtl/prime_sieve_counter_core.sv =====
// prime sieve counter: returns pi(n), the number of primes from 2 to n
// input channel: limit_i with in_valid_i / in_stall_o, a word is taken when
//   valid is high and stall is low; stall is high while a word is in work
// output channel: prime_count_o with out_valid_o / out_stall_i, held in an
//   output register, so the next limit is taken while a result still waits
// per word the sieve runs three passes over a 1-bit scratch bitmap with one
//   read/write port: fill entries 0..n, clear multiples of each marked base
//   b with b*b <= n, then count marked entries 2..n
// the bitmap has a single read/write port, one access a cycle, so each
//   pass walks its entries one at a time
// a limit below 2 skips the sieve and gives 0
// words are handled one at a time: a new limit is taken only after the
//   last result is published
// reset clears the controller and the output valid; the bitmap is not
//   cleared, every entry read is written earlier in the same word
// a stalled result holds its value until taken; a finished word waits in
//   its last state until the output register is free
module prime_sieve_counter_core import psc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [LIMIT_W-1:0] limit_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  output logic [COUNT_W-1:0] prime_count_o,
  output logic               out_valid_o,
  input  logic               out_stall_i
);

  dp_op_e      dp_op;
  psc_status_t dp_status;

  // sequencer for the fill, mark and count passes
  psc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (dp_status),
    .op_o        (dp_op)
  );

  // bitmap, index counters and result register
  psc_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .limit_i       (limit_i),
    .op_i          (dp_op),
    .status_o      (dp_status),
    .prime_count_o (prime_count_o)
  );

endmodule

// ===== hw/rtl/psc_dp.sv =====
module psc_dp import psc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [LIMIT_W-1:0] limit_i,
  input  dp_op_e             op_i,
  output psc_status_t        status_o,
  output logic [COUNT_W-1:0] prime_count_o
);

  localparam int SatW = (LIMIT_W > ADDR_W) ? LIMIT_W : ADDR_W;
  localparam logic [ADDR_W-1:0] MaxN = ADDR_W'(MAX_LIMIT_PLUS_ONE - 1);

  logic [ADDR_W-1:0]  n_q, n_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic [BASE_W-1:0]  base_q, base_d;
  logic [IDX_W-1:0]   sq_q, sq_d;
  logic [COUNT_W-1:0] cnt_q, cnt_d;
  logic [COUNT_W-1:0] result_q, result_d;
  logic               pend_q;

  logic               mem [MAX_LIMIT_PLUS_ONE];
  logic               rdata_q;
  logic [ADDR_W-1:0]  mem_addr;
  logic               mem_we;
  logic               mem_wbit;
  logic [IDX_W-1:0]   n_ext;

  assign n_ext = IDX_W'(n_q);

  always_comb begin
    n_d      = n_q;
    idx_d    = idx_q;
    base_d   = base_q;
    sq_d     = sq_q;
    cnt_d    = cnt_q;
    result_d = result_q;
    mem_we   = 1'b0;
    mem_wbit = 1'b0;
    mem_addr = idx_q[ADDR_W-1:0];

    // accumulate the bit read in the previous cycle during the count pass
    if (pend_q && rdata_q && (cnt_q != COUNT_MAX)) begin
      cnt_d = cnt_q + COUNT_W'(1);
    end

    case (op_i)
      DP_LOAD: begin
        if (SatW'(limit_i) > SatW'(MaxN)) begin
          n_d = MaxN;
        end else begin
          n_d = ADDR_W'(limit_i);
        end
        idx_d = '0;
        cnt_d = '0;
      end
      DP_FILL: begin
        mem_we   = 1'b1;
        mem_wbit = 1'b1;
        idx_d    = idx_q + IDX_W'(1);
      end
      DP_BASE_INIT: begin
        base_d = BASE_W'(2);
        sq_d   = IDX_W'(4);
      end
      DP_BASE_RD: begin
        mem_addr = ADDR_W'(base_q);
      end
      DP_MARK_INIT: begin
        idx_d = sq_q;
      end
      DP_MARK: begin
        mem_we   = 1'b1;
        mem_wbit = 1'b0;
        idx_d    = idx_q + IDX_W'(base_q);
      end
      DP_BASE_NEXT: begin
        // (b+1)^2 = b^2 + 2b + 1
        base_d = base_q + BASE_W'(1);
        sq_d   = sq_q + IDX_W'({base_q, 1'b1});
      end
      DP_CNT_INIT: begin
        idx_d = IDX_W'(2);
        cnt_d = '0;
      end
      DP_CNT_RD: begin
        idx_d = idx_q + IDX_W'(1);
      end
      DP_PUBLISH: begin
        result_d = cnt_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wbit;
    end
    rdata_q <= mem[mem_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q      <= '0;
      idx_q    <= '0;
      base_q   <= '0;
      sq_q     <= '0;
      cnt_q    <= '0;
      result_q <= '0;
      pend_q   <= 1'b0;
    end else begin
      n_q      <= n_d;
      idx_q    <= idx_d;
      base_q   <= base_d;
      sq_q     <= sq_d;
      cnt_q    <= cnt_d;
      result_q <= result_d;
      pend_q   <= (op_i == DP_CNT_RD);
    end
  end

  assign status_o.n_lt2       = (n_q < ADDR_W'(2));
  assign status_o.idx_eq_n    = (idx_q == n_ext);
  assign status_o.idx_gt_n    = (idx_q > n_ext);
  assign status_o.sq_gt_n     = (sq_q > n_ext);
  assign status_o.base_marked = rdata_q;

  assign prime_count_o = result_q;

endmodule

// ===== hw/rtl/psc_ctrl.sv =====
module psc_ctrl import psc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  input  psc_status_t status_i,
  output dp_op_e      op_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_FILL,
    ST_BASE_INIT,
    ST_BASE_TEST,
    ST_BASE_CHK,
    ST_MARK,
    ST_CNT_INIT,
    ST_CNT,
    ST_CNT_DRAIN,
    ST_DONE
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  assign slot_free  = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    state_d     = state_q;
    op_o        = DP_NOP;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          op_o    = DP_LOAD;
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        // limits below two skip the sieve, count is already zero
        state_d = status_i.n_lt2 ? ST_DONE : ST_FILL;
      end
      ST_FILL: begin
        op_o = DP_FILL;
        if (status_i.idx_eq_n) begin
          state_d = ST_BASE_INIT;
        end
      end
      ST_BASE_INIT: begin
        op_o    = DP_BASE_INIT;
        state_d = ST_BASE_TEST;
      end
      ST_BASE_TEST: begin
        if (status_i.sq_gt_n) begin
          state_d = ST_CNT_INIT;
        end else begin
          op_o    = DP_BASE_RD;
          state_d = ST_BASE_CHK;
        end
      end
      ST_BASE_CHK: begin
        if (status_i.base_marked) begin
          op_o    = DP_MARK_INIT;
          state_d = ST_MARK;
        end else begin
          op_o    = DP_BASE_NEXT;
          state_d = ST_BASE_TEST;
        end
      end
      ST_MARK: begin
        if (status_i.idx_gt_n) begin
          op_o    = DP_BASE_NEXT;
          state_d = ST_BASE_TEST;
        end else begin
          op_o = DP_MARK;
        end
      end
      ST_CNT_INIT: begin
        op_o    = DP_CNT_INIT;
        state_d = ST_CNT;
      end
      ST_CNT: begin
        op_o = DP_CNT_RD;
        if (status_i.idx_eq_n) begin
          state_d = ST_CNT_DRAIN;
        end
      end
      ST_CNT_DRAIN: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (slot_free) begin
          op_o        = DP_PUBLISH;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== hw/rtl/psc_chk.sv =====
module psc_chk import psc_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic [COUNT_W-1:0] prime_count_o,
  input logic               out_valid_o,
  input logic               out_stall_i
);

  // a stalled result stays put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(prime_count_o)))
    else $error("stalled result changed");

  // one word at a time: an accepted limit closes the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input open right after accept");

  // a new result appears only as the sieve goes back to idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !in_stall_o)
    else $error("result raised while busy");

  // count never exceeds pi of the largest limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (prime_count_o <= PRIME_COUNT_MAX))
    else $error("prime count out of range");

endmodule

bind prime_sieve_counter_core psc_chk u_psc_chk (.*);
